[rtl/lrs_pkg.sv]
// Shared types and constants for the labeled region statistics block.
package lrs_pkg;

    // Field and accumulator widths
    localparam int unsigned COORD_W = 10;
    localparam int unsigned LABEL_W = 8;
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned CNT_W   = 21;
    localparam int unsigned SUM_W   = 31;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned IDX_W   = 2;

    // Packed stream widths
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 96;

    // Saturation limits
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_TARGET_LABEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_REGION_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Division jobs run on the shared divider
    localparam logic [1:0] OP_CX  = 2'd0;
    localparam logic [1:0] OP_CY  = 2'd1;
    localparam logic [1:0] OP_AVG = 2'd2;

    // Size and orientation classes
    localparam logic [1:0] SIZE_SMALL  = 2'd0;
    localparam logic [1:0] SIZE_MEDIUM = 2'd1;
    localparam logic [1:0] SIZE_LARGE  = 2'd2;
    localparam logic [1:0] ORIENT_TALL = 2'd0;
    localparam logic [1:0] ORIENT_WIDE = 2'd1;
    localparam logic [1:0] ORIENT_SYM  = 2'd2;
    localparam logic       SHAPE_SQUARE = 1'b0;
    localparam logic       SHAPE_RECT   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       pix_en;
        logic       div_start;
        logic       q_load;
        logic [1:0] op;
        logic       emit;
    } lrs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } lrs_sts_t;

endpackage

[rtl/labeled_region_statistics.sv]
// Measures one labeled region of a streamed map: area, centroid, box and size classes.
//
// Input stream (s_): one pixel per item, column, row and label in s_tdata, s_tlast marks
// the final pixel of the map. Pixels are taken one per cycle while accumulating.
// Result stream (m_): one item per map carrying area, centroid, bounding box, shape,
// size and orientation classes and an empty flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 target label,
// 1 region count, 2 image width, 3 image height); write only while the block is idle.
// After the last pixel the shared bit-serial divider runs three divisions: centroid
// column, centroid row and average region size. s_tready stays low while they run.
// The result sits in an output register; once loaded the accumulators clear and the
// next map streams in even while the receiver stalls. If a second result is ready
// before the first is taken, the block holds with s_tready low until m_tready.
// Reset (aresetn low, synchronous) restores register defaults and clears all sums.
module labeled_region_statistics
    import lrs_pkg::*;
#(
    parameter int unsigned MAX_DIM = 1024
)
(
    input  logic                aclk,
    input  logic                aresetn,
    // config write port
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // pixel stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // pixel_x [9:0], pixel_y [19:10], pixel_label [27:20], zero fill [31:28]
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // region_area [20:0], center_x [30:21], center_y [40:31], box_left [51:41],
    // box_top [62:52], box_right [72:63], box_bottom [82:73], shape_code [83],
    // size_code [85:84], orient_code [87:86], empty_region [88], zero fill [95:89]
    output logic [M_DATA_W-1:0] m_tdata
);

    lrs_cmd_t cmd;
    lrs_sts_t sts;

    lrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrs_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/lrs_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module lrs_div
    import lrs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int unsigned STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  diff;

    // One trial subtraction per step
    always_comb begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[SUM_W-2:0], ~diff[CNT_W+1]};
            rem_next = diff[CNT_W+1] ? shifted[CNT_W-1:0] : diff[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operands
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/lrs_dp.sv]
// Datapath: configuration, accumulators, divider operands, classification, result register.
module lrs_dp
    import lrs_pkg::*;
#(
    parameter int unsigned MAX_DIM = 1024
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  lrs_cmd_t            cmd,
    output lrs_sts_t            sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(MAX_DIM);

    // Configuration
    logic [LABEL_W-1:0] target_reg;
    logic [LABEL_W-1:0] regions_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    // Accumulators
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   colsum_reg, colsum_next;
    logic [SUM_W-1:0]   rowsum_reg, rowsum_next;
    logic [DIM_W-1:0]   mincol_reg, mincol_next;
    logic [DIM_W-1:0]   minrow_reg, minrow_next;
    logic [COORD_W-1:0] maxcol_reg, maxcol_next;
    logic [COORD_W-1:0] maxrow_reg, maxrow_next;
    logic [CNT_W-1:0]   nonzero_reg, nonzero_next;

    // Quotients
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic [CNT_W-1:0]   avg_reg;

    // Result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [COORD_W-1:0] px, py;
    logic [LABEL_W-1:0] plabel;
    logic               hit, empty;
    logic [SUM_W:0]     colsum_add, rowsum_add;

    logic [SUM_W-1:0]   dividend;
    logic [CNT_W-1:0]   divisor;
    logic [LABEL_W-1:0] regions_eff;
    logic               div_done;
    logic [SUM_W-1:0]   quotient;
    logic [COORD_W-1:0] quo_sat;

    logic [DIM_W-1:0]   box_w, box_h;
    logic [DIM_W+3:0]   w13, w10, h13, h10;
    logic               shape;
    logic [1:0]         orient, size;
    logic [CNT_W:0]     twice_area;
    logic [CNT_W+1:0]   three_avg;
    logic [COORD_W-1:0] res_cx, res_cy;

    assign px     = s_tdata[COORD_W-1:0];
    assign py     = s_tdata[2*COORD_W-1:COORD_W];
    assign plabel = s_tdata[2*COORD_W+LABEL_W-1:2*COORD_W];
    assign hit    = (plabel == target_reg);
    assign empty  = (count_reg == '0);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= LABEL_W'(1);
            regions_reg <= LABEL_W'(27);
            width_reg   <= DIM_RST;
            height_reg  <= DIM_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TARGET_LABEL: target_reg  <= cfg_wdata[LABEL_W-1:0];
                REG_REGION_COUNT: regions_reg <= cfg_wdata[LABEL_W-1:0];
                REG_IMAGE_WIDTH:  width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Accumulate one pixel, reload box edges on size writes while the region is empty, clear after a result
    always_comb begin
        colsum_add   = {1'b0, colsum_reg} + {{(SUM_W+1-COORD_W){1'b0}}, px};
        rowsum_add   = {1'b0, rowsum_reg} + {{(SUM_W+1-COORD_W){1'b0}}, py};
        count_next   = count_reg;
        colsum_next  = colsum_reg;
        rowsum_next  = rowsum_reg;
        mincol_next  = mincol_reg;
        minrow_next  = minrow_reg;
        maxcol_next  = maxcol_reg;
        maxrow_next  = maxrow_reg;
        nonzero_next = nonzero_reg;
        if (cmd.emit) begin
            count_next   = '0;
            colsum_next  = '0;
            rowsum_next  = '0;
            mincol_next  = width_reg;
            minrow_next  = height_reg;
            maxcol_next  = '0;
            maxrow_next  = '0;
            nonzero_next = '0;
        end else if (cmd.pix_en) begin
            if (hit) begin
                if (count_reg != CNT_MAX) count_next = count_reg + 1'b1;
                colsum_next = colsum_add[SUM_W] ? SUM_MAX : colsum_add[SUM_W-1:0];
                rowsum_next = rowsum_add[SUM_W] ? SUM_MAX : rowsum_add[SUM_W-1:0];
                if ({1'b0, px} < mincol_reg) mincol_next = {1'b0, px};
                if ({1'b0, py} < minrow_reg) minrow_next = {1'b0, py};
                if (px > maxcol_reg) maxcol_next = px;
                if (py > maxrow_reg) maxrow_next = py;
            end
            if ((plabel != '0) && (nonzero_reg != CNT_MAX)) nonzero_next = nonzero_reg + 1'b1;
        end else if (cfg_we && empty) begin
            if (cfg_addr == REG_IMAGE_WIDTH)  mincol_next = cfg_wdata[DIM_W-1:0];
            if (cfg_addr == REG_IMAGE_HEIGHT) minrow_next = cfg_wdata[DIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            colsum_reg  <= '0;
            rowsum_reg  <= '0;
            mincol_reg  <= DIM_RST;
            minrow_reg  <= DIM_RST;
            maxcol_reg  <= '0;
            maxrow_reg  <= '0;
            nonzero_reg <= '0;
        end else begin
            count_reg   <= count_next;
            colsum_reg  <= colsum_next;
            rowsum_reg  <= rowsum_next;
            mincol_reg  <= mincol_next;
            minrow_reg  <= minrow_next;
            maxcol_reg  <= maxcol_next;
            maxrow_reg  <= maxrow_next;
            nonzero_reg <= nonzero_next;
        end
    end

    // Divider operands; a region count of zero divides by one
    assign regions_eff = (regions_reg == '0) ? LABEL_W'(1) : regions_reg;

    always_comb begin
        unique case (cmd.op)
            OP_CX: begin
                dividend = colsum_reg;
                divisor  = count_reg;
            end
            OP_CY: begin
                dividend = rowsum_reg;
                divisor  = count_reg;
            end
            default: begin
                dividend = {{(SUM_W-CNT_W){1'b0}}, nonzero_reg};
                divisor  = {{(CNT_W-LABEL_W){1'b0}}, regions_eff};
            end
        endcase
    end

    lrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Capture quotients, centroid saturates at the top coordinate
    assign quo_sat = (quotient[SUM_W-1:COORD_W] != '0) ? COORD_MAX : quotient[COORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.q_load) begin
            unique case (cmd.op)
                OP_CX:   cx_reg  <= quo_sat;
                OP_CY:   cy_reg  <= quo_sat;
                default: avg_reg <= quotient[CNT_W-1:0];
            endcase
        end
    end

    // Shape and orientation by 13/10 cross products
    always_comb begin
        box_w = ({1'b0, maxcol_reg} >= mincol_reg) ? ({1'b0, maxcol_reg} - mincol_reg) : '0;
        box_h = ({1'b0, maxrow_reg} >= minrow_reg) ? ({1'b0, maxrow_reg} - minrow_reg) : '0;
        w13   = (DIM_W+4)'(box_w) * (DIM_W+4)'(13);
        w10   = (DIM_W+4)'(box_w) * (DIM_W+4)'(10);
        h13   = (DIM_W+4)'(box_h) * (DIM_W+4)'(13);
        h10   = (DIM_W+4)'(box_h) * (DIM_W+4)'(10);
        if (empty) begin
            orient = ORIENT_SYM;
            shape  = SHAPE_SQUARE;
        end else if (w13 < h10) begin
            orient = ORIENT_TALL;
            shape  = SHAPE_RECT;
        end else if (w10 > h13) begin
            orient = ORIENT_WIDE;
            shape  = SHAPE_RECT;
        end else begin
            orient = ORIENT_SYM;
            shape  = SHAPE_SQUARE;
        end
    end

    // Size against half and one and a half of the average
    always_comb begin
        twice_area = {count_reg, 1'b0};
        three_avg  = {1'b0, avg_reg, 1'b0} + {2'b00, avg_reg};
        priority if ({1'b0, twice_area} <= {1'b0, avg_reg, 1'b0} - {2'b00, avg_reg}) begin
            size = SIZE_SMALL;
        end else if ({1'b0, twice_area} >= three_avg) begin
            size = SIZE_LARGE;
        end else begin
            size = SIZE_MEDIUM;
        end
    end

    assign res_cx = empty ? '0 : cx_reg;
    assign res_cy = empty ? '0 : cy_reg;

    // Result register, refilled as soon as the receiver takes the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {7'b0, empty, orient, size, shape, maxrow_reg, maxcol_reg,
                           minrow_reg, mincol_reg, res_cy, res_cx, count_reg};
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;

endmodule

[rtl/lrs_ctrl.sv]
// Controller: accepts pixels, sequences the three divisions, hands off the result.
module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    input  lrs_sts_t sts,
    output lrs_cmd_t cmd
);

    localparam logic [1:0] ST_ACCUM  = 2'd0;
    localparam logic [1:0] ST_DSTART = 2'd1;
    localparam logic [1:0] ST_DWAIT  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        s_tready   = (state_reg == ST_ACCUM);
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_tvalid) begin
                    cmd.pix_en = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_DSTART;
                        op_next    = OP_CX;
                    end
                end
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (sts.div_done) begin
                    cmd.q_load = 1'b1;
                    if (op_reg == OP_AVG) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_DSTART;
                        op_next    = op_reg + 2'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            op_reg    <= OP_CX;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

[bench/tb_labeled_region_statistics.sv]
// Self-checking testbench for the labeled region statistics block.
`timescale 1ns / 1ps

module tb_labeled_region_statistics
    import lrs_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned DRAIN_SETTLE    = 120;
    localparam int unsigned NUM_PHASES      = 9;
    localparam int unsigned ITEMS_PER_PHASE = 210;

    // Result item as it sits in m_tdata, highest field first
    typedef struct packed {
        logic [6:0]  zero_fill;
        logic        empty_region;
        logic [1:0]  orient_code;
        logic [1:0]  size_code;
        logic        shape_code;
        logic [9:0]  box_bottom;
        logic [9:0]  box_right;
        logic [10:0] box_top;
        logic [10:0] box_left;
        logic [9:0]  center_y;
        logic [9:0]  center_x;
        logic [20:0] region_area;
    } region_result_t;

    // Region statistics predictor and store of expected region results
    class region_scoreboard;
        logic [7:0]     target_label;
        logic [7:0]     region_count;
        logic [10:0]    image_width;
        logic [10:0]    image_height;
        logic [20:0]    pixel_count;
        logic [20:0]    nonzero_count;
        logic [30:0]    column_sum;
        logic [30:0]    row_sum;
        logic [10:0]    min_column;
        logic [10:0]    min_row;
        logic [9:0]     max_column;
        logic [9:0]     max_row;
        region_result_t expected_q[$];
        int unsigned    errors;
        int unsigned    results_seen;

        function new();
            target_label = 8'd1;
            region_count = 8'd27;
            image_width  = 11'd1024;
            image_height = 11'd1024;
            errors       = 0;
            results_seen = 0;
            clear_accumulators();
        endfunction

        function void clear_accumulators();
            pixel_count   = '0;
            nonzero_count = '0;
            column_sum    = '0;
            row_sum       = '0;
            min_column    = image_width;
            min_row       = image_height;
            max_column    = '0;
            max_row       = '0;
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                          longint unsigned lim);
            longint unsigned s;
            s = a + b;
            return (s > lim) ? lim : s;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_TARGET_LABEL: target_label = value[7:0];
                REG_REGION_COUNT: region_count = value[7:0];
                REG_IMAGE_WIDTH: begin
                    image_width = value;
                    // empty region picks up the new left edge at once
                    if (pixel_count == 0) min_column = value;
                end
                REG_IMAGE_HEIGHT: begin
                    image_height = value;
                    if (pixel_count == 0) min_row = value;
                end
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Accumulate one accepted pixel; on the last pixel predict the region result
        function void note_pixel(logic [9:0] x, logic [9:0] y, logic [7:0] lbl, logic last);
            region_result_t  r;
            longint unsigned mean_x, mean_y, w, h, divisor, avg, twice;
            longint unsigned lo_x, hi_x, lo_y, hi_y;
            if (lbl == target_label) begin
                pixel_count = CNT_W'(sat_add(pixel_count, 1, CNT_MAX));
                column_sum  = SUM_W'(sat_add(column_sum, x, SUM_MAX));
                row_sum     = SUM_W'(sat_add(row_sum, y, SUM_MAX));
                if ({1'b0, x} < min_column) min_column = {1'b0, x};
                if ({1'b0, y} < min_row) min_row = {1'b0, y};
                if (x > max_column) max_column = x;
                if (y > max_row) max_row = y;
            end
            if (lbl != 0) nonzero_count = CNT_W'(sat_add(nonzero_count, 1, CNT_MAX));
            if (!last) return;

            r              = '0;
            r.region_area  = pixel_count;
            r.box_left     = min_column;
            r.box_top      = min_row;
            r.box_right    = max_column;
            r.box_bottom   = max_row;
            r.shape_code   = SHAPE_SQUARE;
            r.orient_code  = ORIENT_SYM;
            r.empty_region = (pixel_count == 0);
            if (!r.empty_region) begin
                mean_x = column_sum / pixel_count;
                mean_y = row_sum / pixel_count;
                r.center_x = (mean_x > COORD_MAX) ? COORD_MAX : mean_x[9:0];
                r.center_y = (mean_y > COORD_MAX) ? COORD_MAX : mean_y[9:0];
                lo_x = min_column;
                hi_x = max_column;
                lo_y = min_row;
                hi_y = max_row;
                w = (hi_x >= lo_x) ? hi_x - lo_x : 0;
                h = (hi_y >= lo_y) ? hi_y - lo_y : 0;
                // integer forms of the 1.3 aspect tests
                if (13 * w < 10 * h) begin
                    r.orient_code = ORIENT_TALL;
                    r.shape_code  = SHAPE_RECT;
                end else if (10 * w > 13 * h) begin
                    r.orient_code = ORIENT_WIDE;
                    r.shape_code  = SHAPE_RECT;
                end
            end
            // size class against the truncated average, zero count taken as one
            divisor = (region_count == 0) ? 1 : region_count;
            avg     = nonzero_count / divisor;
            twice   = 2 * longint'(pixel_count);
            if (twice <= avg)
                r.size_code = SIZE_SMALL;
            else if (twice >= 3 * avg)
                r.size_code = SIZE_LARGE;
            else
                r.size_code = SIZE_MEDIUM;
            expected_q.insert(expected_q.size(), r);
            clear_accumulators();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result item with the oldest expectation
        function void check_result(region_result_t got);
            region_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: result item with none expected, expected nothing, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("region_area", want.region_area, got.region_area);
            compare_field("center_x", want.center_x, got.center_x);
            compare_field("center_y", want.center_y, got.center_y);
            compare_field("box_left", want.box_left, got.box_left);
            compare_field("box_top", want.box_top, got.box_top);
            compare_field("box_right", want.box_right, got.box_right);
            compare_field("box_bottom", want.box_bottom, got.box_bottom);
            compare_field("shape_code", want.shape_code, got.shape_code);
            compare_field("size_code", want.size_code, got.size_code);
            compare_field("orient_code", want.orient_code, got.orient_code);
            compare_field("empty_region", want.empty_region, got.empty_region);
            compare_field("zero_fill", want.zero_fill, got.zero_fill);
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    region_scoreboard sb;
    int unsigned      cycles       = 0;
    int unsigned      pixels_sent  = 0;
    int unsigned      settings_run = 0;
    int unsigned      burst_left   = 0;
    int unsigned      mode_left    = 0;
    int unsigned      stall_left   = 0;
    int unsigned      ready_mode   = 0;

    labeled_region_statistics #(.MAX_DIM(1024)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("labeled_region_statistics verification failed");
            $finish;
        end
    end

    // Result side: check accepted items, then pick the next ready level
    always @(posedge aclk) begin
        logic next_ready;
        if (aresetn && m_tvalid && m_tready) sb.check_result(region_result_t'(m_tdata));
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else begin
            case (ready_mode)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                default: begin
                    // mostly ready, with the odd long stall
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 64);
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                    end
                end
            endcase
        end
        m_tready <= next_ready;
    end

    // One register write; called right after a rising edge
    task automatic program_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    // Send one pixel item, idling between bursts
    task automatic send_pixel(logic [9:0] x, logic [9:0] y, logic [7:0] lbl, logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, lbl, y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(x, y, lbl, last);
        pixels_sent++;
    endtask

    // Hold the sender until every expected result has come, then let the block settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    function automatic int unsigned pick_span();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(1, 15);
            2: return $urandom_range(16, 200);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 3))
            0: return 1;
            1: return 1024;
            default: return $urandom_range(1, 1024);
        endcase
    endfunction

    // One map: pixels in a random box with a random label mix, or pure noise
    task automatic run_map();
        int unsigned n, span_x, span_y, x0, y0, pct_target, pct_zero, r;
        logic        noisy;
        logic [9:0]  x, y;
        logic [7:0]  lbl;
        n          = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150)
                                                 : $urandom_range(1, 24);
        noisy      = ($urandom_range(0, 9) == 0);
        span_x     = pick_span();
        span_y     = pick_span();
        x0         = $urandom_range(0, 1023 - span_x);
        y0         = $urandom_range(0, 1023 - span_y);
        pct_target = $urandom_range(0, 100);
        pct_zero   = $urandom_range(0, 100 - pct_target);
        for (int i = 0; i < n; i++) begin
            if (noisy) begin
                x   = 10'($urandom_range(0, 1023));
                y   = 10'($urandom_range(0, 1023));
                lbl = 8'($urandom_range(0, 255));
            end else begin
                x = 10'(x0 + $urandom_range(0, span_x));
                y = 10'(y0 + $urandom_range(0, span_y));
                r = $urandom_range(0, 99);
                if (r < pct_target)
                    lbl = sb.target_label;
                else if (r < pct_target + pct_zero)
                    lbl = 8'd0;
                else
                    lbl = 8'($urandom_range(1, 255));
            end
            send_pixel(x, y, lbl, i == n - 1);
        end
    endtask

    initial begin
        int unsigned tgt, rcount, wdim, hdim, phase_start;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed maps under reset settings (target 1)
        send_pixel(10'd0, 10'd0, 8'd1, 1'b1);         // single pixel, zero-size box
        send_pixel(10'd1023, 10'd1023, 8'd0, 1'b1);   // empty region, background only
        send_pixel(10'd512, 10'd512, 8'd200, 1'b1);   // empty region, other label
        send_pixel(10'd5, 10'd0, 8'd1, 1'b0);         // tall
        send_pixel(10'd5, 10'd100, 8'd1, 1'b1);
        send_pixel(10'd0, 10'd7, 8'd1, 1'b0);         // zero-height box, wide
        send_pixel(10'd100, 10'd7, 8'd1, 1'b1);
        send_pixel(10'd10, 10'd20, 8'd1, 1'b0);       // w 10 h 13: on the tall edge
        send_pixel(10'd20, 10'd33, 8'd1, 1'b1);
        send_pixel(10'd10, 10'd20, 8'd1, 1'b0);       // w 10 h 14: just tall
        send_pixel(10'd20, 10'd34, 8'd1, 1'b1);
        send_pixel(10'd0, 10'd0, 8'd1, 1'b0);         // w 14 h 10: just wide
        send_pixel(10'd14, 10'd10, 8'd1, 1'b1);
        send_pixel(10'd1023, 10'd0, 8'd1, 1'b0);      // full-frame corners
        send_pixel(10'd0, 10'd1023, 8'd255, 1'b0);
        send_pixel(10'd0, 10'd1023, 8'd1, 1'b0);
        send_pixel(10'd1023, 10'd1023, 8'd0, 1'b1);
        wait_drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin tgt = 1;   rcount = 1;   wdim = 1024; hdim = 1024; end
                1: begin tgt = 255; rcount = 255; wdim = 1;    hdim = 1;    end
                2: begin tgt = 2;   rcount = 0;   wdim = 1024; hdim = 1;    end
                3: begin tgt = 128; rcount = 2;   wdim = 1;    hdim = 1024; end
                default: begin
                    tgt    = $urandom_range(1, 255);
                    rcount = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                         : $urandom_range(1, 6);
                    wdim   = pick_dim();
                    hdim   = pick_dim();
                end
            endcase
            program_register(REG_TARGET_LABEL, CFG_W'(tgt));
            program_register(REG_REGION_COUNT, CFG_W'(rcount));
            program_register(REG_IMAGE_WIDTH, CFG_W'(wdim));
            program_register(REG_IMAGE_HEIGHT, CFG_W'(hdim));
            cfg_we <= 1'b0;
            settings_run++;

            phase_start = pixels_sent;
            while (pixels_sent - phase_start < ITEMS_PER_PHASE) begin
                run_map();
                // now and then let everything drain before the next map
                if ($urandom_range(0, 11) == 0) wait_drain();
            end
            wait_drain();
        end

        $display("Sent %0d pixel items, checked %0d region results over %0d register settings",
                 pixels_sent, sb.results_seen, settings_run);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("labeled_region_statistics verification clean");
        end else begin
            $display("labeled_region_statistics verification failed");
        end
        $finish;
    end

endmodule

[labeled_region_statistics.f]
rtl/lrs_pkg.sv
rtl/lrs_div.sv
rtl/lrs_dp.sv
rtl/lrs_ctrl.sv
rtl/labeled_region_statistics.sv
bench/tb_labeled_region_statistics.sv
